// ----- src/dnpu_pkg.sv -----
// ----------------------------------------------------------------------------
// dnpu_pkg: shared definitions for the decimal number property unit
// Mode codes, controller states, command/status bundles and the digit cube
// table used by the datapath.
// ----------------------------------------------------------------------------
package dnpu_pkg;

  localparam int VALUE_BITS_DEF = 32;

  // stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_W  = 40;
  localparam int OUT_W = 8;

  localparam logic [2:0] MODE_PAL   = 3'd0;
  localparam logic [2:0] MODE_ARM   = 3'd1;
  localparam logic [2:0] MODE_PRIME = 3'd2;
  localparam logic [2:0] MODE_DSUM  = 3'd3;
  localparam logic [2:0] MODE_DCNT  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PCHK,
    ST_DIV,
    ST_POST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic digit_acc;
    logic prime_next;
    logic clr_prime;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode_prime;
    logic mode_digit;
    logic t_zero;
    logic rem_zero;
    logic step_last;
    logic sq_gt;
    logic pr;
  } sts_t;

  function automatic logic [9:0] cube(input logic [3:0] d);
    logic [9:0] c;
    case (d)
      4'd0:    c = 10'd0;
      4'd1:    c = 10'd1;
      4'd2:    c = 10'd8;
      4'd3:    c = 10'd27;
      4'd4:    c = 10'd64;
      4'd5:    c = 10'd125;
      4'd6:    c = 10'd216;
      4'd7:    c = 10'd343;
      4'd8:    c = 10'd512;
      4'd9:    c = 10'd729;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/dnpu_ctrl.sv -----
// ----------------------------------------------------------------------------
// dnpu_ctrl: controller for the decimal number property unit
// Sequences digit extraction (staged divide by ten) and trial division
// (shift-subtract divider) and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module dnpu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dnpu_pkg::sts_t  sts,
  output dnpu_pkg::cmd_t  cmd
);

  dnpu_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == dnpu_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dnpu_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = dnpu_pkg::ST_START;
      end
      dnpu_pkg::ST_START: begin
        if (sts.mode_prime) begin
          state_nxt = sts.pr ? dnpu_pkg::ST_PCHK : dnpu_pkg::ST_FINISH;
        end else if (sts.mode_digit) begin
          state_nxt = sts.t_zero ? dnpu_pkg::ST_FINISH : dnpu_pkg::ST_DIV;
        end else begin
          state_nxt = dnpu_pkg::ST_FINISH;
        end
      end
      dnpu_pkg::ST_PCHK: begin
        state_nxt = sts.sq_gt ? dnpu_pkg::ST_FINISH : dnpu_pkg::ST_DIV;
      end
      dnpu_pkg::ST_DIV: begin
        if (sts.step_last) state_nxt = dnpu_pkg::ST_POST;
      end
      dnpu_pkg::ST_POST: begin
        if (sts.mode_prime) begin
          state_nxt = sts.rem_zero ? dnpu_pkg::ST_FINISH : dnpu_pkg::ST_PCHK;
        end else begin
          state_nxt = sts.t_zero ? dnpu_pkg::ST_FINISH : dnpu_pkg::ST_DIV;
        end
      end
      dnpu_pkg::ST_FINISH: begin
        if (out_free) state_nxt = dnpu_pkg::ST_IDLE;
      end
      default: state_nxt = dnpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      dnpu_pkg::ST_IDLE:  cmd.load     = in_tvalid;
      dnpu_pkg::ST_PCHK:  cmd.div_init = !sts.sq_gt;
      dnpu_pkg::ST_DIV:   cmd.div_step = 1'b1;
      dnpu_pkg::ST_POST: begin
        if (sts.mode_prime) begin
          cmd.clr_prime  = sts.rem_zero;
          cmd.prime_next = !sts.rem_zero;
        end else begin
          cmd.digit_acc = 1'b1;
        end
      end
      dnpu_pkg::ST_FINISH: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // hold a finished result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnpu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dnpu_pkg::ST_IDLE) |-> !(cmd.div_step || cmd.digit_acc || cmd.out_load))
    else $error("datapath command issued while idle");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.out_load)
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == dnpu_pkg::ST_START))
    else $error("accepted transaction did not start processing");
`endif

endmodule

// ----- src/dnpu_dpath.sv -----
// ----------------------------------------------------------------------------
// dnpu_dpath: datapath for the decimal number property unit
// Staged shift-add divide by ten for digit extraction, shift-subtract
// divider for trial division, digit accumulators and the result register.
// ----------------------------------------------------------------------------
module dnpu_dpath #(
  parameter int VALUE_BITS = dnpu_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic [2:0]      in_mode,
  input  logic [31:0]     in_value,
  input  dnpu_pkg::cmd_t  cmd,
  output dnpu_pkg::sts_t  sts,
  output logic            out_is_true,
  output logic [6:0]      out_amount
);

  localparam int PW   = VALUE_BITS - 1;               // magnitude bits
  localparam int ND   = (PW * 30103) / 100000 + 1;    // max decimal digits
  localparam int DW   = (PW + 1) / 2 + 1;             // trial divisor bits
  localparam int CNW  = $clog2(PW);
  localparam int RW   = PW + 4;                       // reversed value bits
  localparam int CW   = $clog2(ND * 729 + 1);
  localparam int SW   = $clog2(ND * 9 + 1);
  localparam int NW   = $clog2(ND + 1);
  localparam int EW   = (CW > PW) ? CW : PW;
  localparam int SWX  = (SW > 7) ? SW : 7;
  localparam int NWX  = (NW > 7) ? NW : 7;
  localparam int D10_STEPS = 8;                       // divide-by-ten stages

  logic          in_neg;
  logic [PW-1:0] in_mag;

  generate
    if (VALUE_BITS <= 32) begin : g_narrow
      assign in_neg = in_value[VALUE_BITS-1];
      assign in_mag = in_value[PW-1:0];
    end else begin : g_wide
      assign in_neg = in_value[31];
      assign in_mag = PW'(in_value[30:0]);
    end
  endgenerate

  logic [2:0]     mode_r;
  logic           neg_r;
  logic [PW-1:0]  p_r;
  logic           pr_r;
  logic [PW-1:0]  t_r;
  logic [PW-1:0]  q_r;
  logic [DW-1:0]  rem_r;
  logic [CNW-1:0] cnt_r;
  logic [DW-1:0]  d_r;
  logic [PW:0]    sq_r;
  logic [RW-1:0]  rev_r;
  logic [CW-1:0]  cub_r;
  logic [SW-1:0]  dsum_r;
  logic [NW-1:0]  ncnt_r;
  logic           is_true_r;
  logic [6:0]     amount_r;

  logic [DW:0]    rem_sh;
  logic           q_bit;
  logic [DW-1:0]  rem_nxt;
  logic [PW-1:0]  r_full;
  logic [3:0]     dig;
  logic [SWX-1:0] dsum_x;
  logic [NWX-1:0] ncnt_x;
  logic           flag_nxt;
  logic [6:0]     amount_nxt;

  assign rem_sh  = {rem_r, t_r[PW-1]};
  assign q_bit   = (rem_sh >= {1'b0, d_r});
  assign rem_nxt = q_bit ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];
  // t minus ten times the quotient estimate, lands in 0..19
  assign r_full  = t_r - (q_r << 3) - (q_r << 1);
  assign dig     = rem_r[3:0];
  assign dsum_x  = SWX'(dsum_r);
  assign ncnt_x  = NWX'(ncnt_r);

  always_comb begin
    flag_nxt   = 1'b0;
    amount_nxt = '0;
    case (mode_r)
      dnpu_pkg::MODE_PAL:   flag_nxt   = !neg_r && (rev_r == RW'(p_r));
      dnpu_pkg::MODE_ARM:   flag_nxt   = !neg_r && (EW'(cub_r) == EW'(p_r));
      dnpu_pkg::MODE_PRIME: flag_nxt   = pr_r;
      dnpu_pkg::MODE_DSUM:  amount_nxt = dsum_x[6:0];
      dnpu_pkg::MODE_DCNT:  amount_nxt = ncnt_x[6:0];
      default: begin
        flag_nxt   = 1'b0;
        amount_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      neg_r  <= in_neg;
      p_r    <= in_mag;
      pr_r   <= !in_neg && (in_mag[PW-1:1] != '0);
      t_r    <= in_neg ? '0 : in_mag;
      rem_r  <= '0;
      cnt_r  <= '0;
      d_r    <= DW'(2);
      sq_r   <= (PW+1)'(4);
      rev_r  <= '0;
      cub_r  <= '0;
      dsum_r <= '0;
      ncnt_r <= '0;
    end
    if (cmd.div_init) begin
      t_r   <= p_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + CNW'(1);
      if (mode_r == dnpu_pkg::MODE_PRIME) begin
        t_r   <= {t_r[PW-2:0], q_bit};
        rem_r <= rem_nxt;
      end else begin
        // t / 10 by reciprocal shift-add: estimate, scale, remainder, correction
        case (cnt_r)
          CNW'(0): q_r <= (t_r >> 1) + (t_r >> 2);
          CNW'(1): q_r <= q_r + (q_r >> 4);
          CNW'(2): q_r <= q_r + (q_r >> 8);
          CNW'(3): q_r <= q_r + (q_r >> 16);
          CNW'(4): q_r <= q_r + (q_r >> 32);
          CNW'(5): q_r <= q_r >> 3;
          CNW'(6): rem_r <= r_full[DW-1:0];
          CNW'(7): begin
            // estimate may be one low: fold the extra ten back in
            if (rem_r > DW'(9)) begin
              t_r   <= q_r + PW'(1);
              rem_r <= rem_r - DW'(10);
            end else begin
              t_r <= q_r;
            end
          end
          default: ;
        endcase
      end
    end
    if (cmd.digit_acc) begin
      rev_r  <= (rev_r << 3) + (rev_r << 1) + RW'(dig);
      cub_r  <= cub_r + CW'(dnpu_pkg::cube(dig));
      dsum_r <= dsum_r + SW'(dig);
      ncnt_r <= ncnt_r + NW'(1);
      rem_r  <= '0;
      cnt_r  <= '0;
    end
    // advance to the next trial divisor: (d+1)^2 = d^2 + 2d + 1
    if (cmd.prime_next) begin
      d_r  <= d_r + DW'(1);
      sq_r <= sq_r + (PW+1)'({d_r, 1'b1});
    end
    if (cmd.clr_prime) begin
      pr_r <= 1'b0;
    end
    if (cmd.out_load) begin
      is_true_r <= flag_nxt;
      amount_r  <= amount_nxt;
    end
  end

  always_comb begin
    sts.mode_prime = (mode_r == dnpu_pkg::MODE_PRIME);
    sts.mode_digit = (mode_r == dnpu_pkg::MODE_PAL)  || (mode_r == dnpu_pkg::MODE_ARM) ||
                     (mode_r == dnpu_pkg::MODE_DSUM) || (mode_r == dnpu_pkg::MODE_DCNT);
    sts.t_zero     = (t_r == '0);
    sts.rem_zero   = (rem_r == '0);
    sts.step_last  = (mode_r == dnpu_pkg::MODE_PRIME) ? (cnt_r == CNW'(PW - 1))
                                                      : (cnt_r == CNW'(D10_STEPS - 1));
    sts.sq_gt      = (sq_r > {1'b0, p_r});
    sts.pr         = pr_r;
  end

  assign out_is_true = is_true_r;
  assign out_amount  = amount_r;

endmodule

// ----- src/decimal_number_property_unit.sv -----
// Digit modes: each decimal digit takes 8 divide-by-ten stages and an accumulate;
//   zero or negative values skip digit extraction.
// Prime mode: a check, a divide and a post step per trial divisor, divisors 2..floor(sqrt(n));
//   worst case for 32 bits about 46341 trial divisors.
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Reset: rst_n synchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
// decimal_number_property_unit: decimal digit properties and primality
// Palindrome, Armstrong, trial-division prime test, digit sum and digit
// count of a signed integer, over stream input and output channels.
// ----------------------------------------------------------------------------
module decimal_number_property_unit #(
  parameter int VALUE_BITS = dnpu_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [dnpu_pkg::IN_W-1:0]  in_tdata,   // [2:0] mode, [34:3] value, rest zero
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [dnpu_pkg::OUT_W-1:0] out_tdata   // [0] is_true, [7:1] amount
);

  dnpu_pkg::cmd_t cmd;
  dnpu_pkg::sts_t sts;
  logic           res_is_true;
  logic [6:0]     res_amount;

  dnpu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dnpu_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .in_mode     (in_tdata[2:0]),
    .in_value    (in_tdata[34:3]),
    .cmd         (cmd),
    .sts         (sts),
    .out_is_true (res_is_true),
    .out_amount  (res_amount)
  );

  assign out_tdata = {res_amount, res_is_true};

endmodule
